### design/adec_pkg.sv
// Shared types, codes and helper functions for the archive stream decryptor.
// No dependencies; the other design files that use it refer to this package by scoped names.
`default_nettype none

package adec_pkg;

  // Decoder phases
  typedef enum logic [2:0] {
    PH_HEADER  = 3'd0,
    PH_NAMELEN = 3'd1,
    PH_NAME    = 3'd2,
    PH_SIZE    = 3'd3,
    PH_DATA    = 3'd4
  } phase_t;

  // Result kinds
  localparam logic [1:0] KIND_NAME = 2'd0;
  localparam logic [1:0] KIND_DATA = 2'd1;
  localparam logic [1:0] KIND_MARK = 2'd2;

  // Status codes
  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_BAD_MAGIC = 3'd1;
  localparam logic [2:0] ST_BAD_NAME  = 3'd2;
  localparam logic [2:0] ST_TRUNC     = 3'd3;
  localparam logic [2:0] ST_UNSUP     = 3'd4;

  // Configuration register indexes
  localparam int unsigned CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_INITIAL_KEY = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_NAME_LIMIT  = 2'd1;

  localparam logic [31:0] INITIAL_KEY_RST = 32'hDEADCAFE;
  localparam logic [15:0] NAME_LIMIT_RST  = 16'd4096;

  // Header version bytes
  localparam logic [7:0] VER_ONE   = 8'h01;
  localparam logic [7:0] VER_THREE = 8'h03;

  // Result queue between the front and back halves
  localparam int unsigned FIFO_DEPTH = 4;
  localparam int unsigned FIFO_AW    = $clog2(FIFO_DEPTH);

  // One queued result candidate
  typedef struct packed {
    logic [7:0] byte_val;   // decrypted byte (name byte still to be filtered when chk is set)
    logic [1:0] kind;
    logic       chk;        // name byte still to be filtered
    logic       force_out;  // must produce a result even if the byte is dropped
    logic       entry_end;
    logic       done;
    logic [2:0] status;
  } adec_rec_t;

  // Metadata / data key step: k*7 + 3 modulo 2^32
  function automatic logic [31:0] key_step(input logic [31:0] k);
    return (k << 3) - k + 32'd3;
  endfunction

  // First seven bytes of the archive magic
  function automatic logic [7:0] magic_byte(input logic [2:0] idx);
    logic [7:0] m;
    unique case (idx)
      3'd0:    m = 8'h52;
      3'd1:    m = 8'h47;
      3'd2:    m = 8'h53;
      3'd3:    m = 8'h53;
      3'd4:    m = 8'h41;
      3'd5:    m = 8'h44;
      default: m = 8'h00;
    endcase
    return m;
  endfunction

endpackage

`default_nettype wire

### design/adec_in_if.sv
// Input byte channel: valid/ready handshake with raw archive byte and end flag.
// No dependencies.
`default_nettype none

interface adec_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       stream_end;

  modport source (output valid, in_byte, stream_end, input ready);
  modport sink   (input valid, in_byte, stream_end, output ready);
endinterface

`default_nettype wire

### design/adec_out_if.sv
// Result channel: valid/ready handshake with the decoded result fields.
// No dependencies.
`default_nettype none

interface adec_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic [1:0] kind;
  logic       entry_end;
  logic       archive_done;
  logic [2:0] status;

  modport source (output valid, out_byte, kind, entry_end, archive_done, status,
                  input ready);
  modport sink   (input valid, out_byte, kind, entry_end, archive_done, status,
                  output ready);
endinterface

`default_nettype wire

### design/adec_cfg_if.sv
// Configuration write channel: valid/ready with register index and write data.
// Depends on adec_pkg for the index width.
`default_nettype none

interface adec_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [adec_pkg::CFG_IDX_W-1:0] index;
  logic [31:0]                    data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

### design/adec_fifo.sv
// Short result queue between the decoder front and the output back end.
// Depends on adec_pkg for the record type and depth.
`default_nettype none

module adec_fifo (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                push,
  input  wire adec_pkg::adec_rec_t push_rec,
  output logic                     full,
  input  wire logic                pop,
  output adec_pkg::adec_rec_t      head_rec,
  output logic                     empty
);

  adec_pkg::adec_rec_t           mem_r [adec_pkg::FIFO_DEPTH];
  logic [adec_pkg::FIFO_AW-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [adec_pkg::FIFO_AW-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [adec_pkg::FIFO_AW:0]    count_r, count_nxt;

  assign full     = (count_r == (adec_pkg::FIFO_AW+1)'(adec_pkg::FIFO_DEPTH));
  assign empty    = (count_r == '0);
  assign head_rec = mem_r[rd_ptr_r];

  // Pointer and fill count update
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = rd_ptr_r + 1'b1;
    end
    unique case ({push, pop})
      2'b10:   count_nxt = count_r + 1'b1;
      2'b01:   count_nxt = count_r - 1'b1;
      default: count_nxt = count_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Storage, no reset needed
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_rec;
    end
  end

endmodule

`default_nettype wire

### design/adec_front.sv
// Decoder front: accepts archive bytes, tracks the container layout and keys,
// and queues one result candidate per byte where one arises. Depends on adec_pkg.
`default_nettype none

module adec_front (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  // byte input
  input  wire logic                           in_valid,
  output logic                                in_ready,
  input  wire logic [7:0]                     in_byte,
  input  wire logic                           stream_end,
  // configuration writes
  input  wire logic                           cfg_wr,
  input  wire logic [adec_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [31:0]                    cfg_data,
  // queue side
  input  wire logic                           q_full,
  output logic                                q_push,
  output adec_pkg::adec_rec_t                 q_rec
);

  // Configuration registers
  logic [31:0] initial_key_r;
  logic [15:0] name_limit_r;

  // Decoder state
  adec_pkg::phase_t phase_r, phase_s, phase_nxt;
  logic [31:0] meta_key_r, meta_key_s, meta_key_nxt;
  logic [31:0] data_key_r, data_key_s, data_key_nxt;
  logic [31:0] byte_count_r, byte_count_s, byte_count_nxt;
  logic [31:0] field_value_r, field_value_s, field_value_nxt;
  logic        name_cut_r, name_cut_s, name_cut_nxt;
  logic        failed_r, failed_nxt;

  logic        step;
  logic [1:0]  lane;
  logic [31:0] word_acc, word_v, meta_step, data_step, bc_inc, dk_shift;
  logic [7:0]  d_name, d_data;
  logic        word_last, hdr_last, magic_hit, name_len_bad, count_end;
  logic [2:0]  hdr_st;
  logic        step_fail, boundary;
  logic        have, chk;

  assign in_ready = !q_full;
  assign step     = in_valid && !q_full && !failed_r;

  // Shared datapath terms
  assign lane         = byte_count_r[1:0];
  assign word_acc     = field_value_r | ({24'd0, in_byte} << {lane, 3'b000});
  assign word_v       = word_acc ^ meta_key_r;
  assign meta_step    = adec_pkg::key_step(meta_key_r);
  assign data_step    = adec_pkg::key_step(data_key_r);
  assign bc_inc       = byte_count_r + 32'd1;
  assign dk_shift     = data_key_r >> {lane, 3'b000};
  assign d_name       = in_byte ^ meta_key_r[7:0];
  assign d_data       = in_byte ^ dk_shift[7:0];
  assign word_last    = (lane == 2'd3);
  assign hdr_last     = (byte_count_r[2:0] == 3'd7);
  assign magic_hit    = (in_byte == adec_pkg::magic_byte(byte_count_r[2:0]));
  assign name_len_bad = (word_v == 32'd0) || (word_v > {16'd0, name_limit_r});
  assign count_end    = (bc_inc >= field_value_r);

  // Header verdict on the eighth byte
  always_comb begin
    if ((field_value_r != 32'd0) ||
        ((in_byte != adec_pkg::VER_ONE) && (in_byte != adec_pkg::VER_THREE))) begin
      hdr_st = adec_pkg::ST_BAD_MAGIC;
    end else if (in_byte == adec_pkg::VER_THREE) begin
      hdr_st = adec_pkg::ST_UNSUP;
    end else begin
      hdr_st = adec_pkg::ST_OK;
    end
  end

  assign step_fail = ((phase_r == adec_pkg::PH_HEADER) && hdr_last &&
                      (hdr_st != adec_pkg::ST_OK)) ||
                     ((phase_r == adec_pkg::PH_NAMELEN) && word_last && name_len_bad);

  // State after one byte, before end-of-stream handling
  always_comb begin
    phase_s       = phase_r;
    meta_key_s    = meta_key_r;
    data_key_s    = data_key_r;
    byte_count_s  = byte_count_r;
    field_value_s = field_value_r;
    name_cut_s    = name_cut_r;
    unique case (phase_r)
      adec_pkg::PH_HEADER: begin
        if (!hdr_last) begin
          if (!magic_hit) begin
            field_value_s = field_value_r | 32'd1;
          end
          byte_count_s = bc_inc;
        end else if (hdr_st == adec_pkg::ST_OK) begin
          meta_key_s    = initial_key_r;
          phase_s       = adec_pkg::PH_NAMELEN;
          byte_count_s  = '0;
          field_value_s = '0;
        end
      end
      adec_pkg::PH_NAMELEN: begin
        field_value_s = word_acc;
        byte_count_s  = bc_inc;
        if (word_last) begin
          meta_key_s = meta_step;
          if (!name_len_bad) begin
            field_value_s = word_v;
            byte_count_s  = '0;
            name_cut_s    = 1'b0;
            phase_s       = adec_pkg::PH_NAME;
          end
        end
      end
      adec_pkg::PH_NAME: begin
        meta_key_s   = meta_step;
        byte_count_s = bc_inc;
        if (!name_cut_r && (d_name == 8'd0)) begin
          name_cut_s = 1'b1;
        end
        if (count_end) begin
          phase_s       = adec_pkg::PH_SIZE;
          byte_count_s  = '0;
          field_value_s = '0;
          name_cut_s    = 1'b0;
        end
      end
      adec_pkg::PH_SIZE: begin
        field_value_s = word_acc;
        byte_count_s  = bc_inc;
        if (word_last) begin
          meta_key_s   = meta_step;
          data_key_s   = meta_step;
          byte_count_s = '0;
          if (word_v == 32'd0) begin
            field_value_s = '0;
            phase_s       = adec_pkg::PH_NAMELEN;
          end else begin
            field_value_s = word_v;
            phase_s       = adec_pkg::PH_DATA;
          end
        end
      end
      adec_pkg::PH_DATA: begin
        if (word_last) begin
          data_key_s = data_step;
        end
        byte_count_s = bc_inc;
        if (count_end) begin
          phase_s       = adec_pkg::PH_NAMELEN;
          byte_count_s  = '0;
          field_value_s = '0;
        end
      end
      default: begin
        phase_s       = adec_pkg::PH_HEADER;
        meta_key_s    = '0;
        data_key_s    = '0;
        byte_count_s  = '0;
        field_value_s = '0;
        name_cut_s    = 1'b0;
      end
    endcase
  end

  assign boundary = (phase_s == adec_pkg::PH_NAMELEN) && (byte_count_s == 32'd0);

  // Next state: commit the step, then apply end-of-stream
  always_comb begin
    phase_nxt       = phase_r;
    meta_key_nxt    = meta_key_r;
    data_key_nxt    = data_key_r;
    byte_count_nxt  = byte_count_r;
    field_value_nxt = field_value_r;
    name_cut_nxt    = name_cut_r;
    failed_nxt      = failed_r;
    if (step) begin
      phase_nxt       = phase_s;
      meta_key_nxt    = meta_key_s;
      data_key_nxt    = data_key_s;
      byte_count_nxt  = byte_count_s;
      field_value_nxt = field_value_s;
      name_cut_nxt    = name_cut_s;
      failed_nxt      = step_fail;
      if (stream_end && !step_fail) begin
        if (boundary) begin
          // clean end: ready for a new archive
          phase_nxt       = adec_pkg::PH_HEADER;
          meta_key_nxt    = '0;
          data_key_nxt    = '0;
          byte_count_nxt  = '0;
          field_value_nxt = '0;
          name_cut_nxt    = 1'b0;
        end else begin
          failed_nxt = 1'b1;
        end
      end
    end
  end

  // Result candidate for this byte
  always_comb begin
    q_rec           = '0;
    q_rec.kind      = adec_pkg::KIND_MARK;
    q_rec.status    = adec_pkg::ST_OK;
    have            = 1'b0;
    chk             = 1'b0;
    unique case (phase_r)
      adec_pkg::PH_HEADER: begin
        if (hdr_last && (hdr_st != adec_pkg::ST_OK)) begin
          have         = 1'b1;
          q_rec.status = hdr_st;
        end
      end
      adec_pkg::PH_NAMELEN: begin
        if (word_last && name_len_bad) begin
          have         = 1'b1;
          q_rec.status = adec_pkg::ST_BAD_NAME;
        end
      end
      adec_pkg::PH_NAME: begin
        if (!name_cut_r && (d_name != 8'd0)) begin
          chk            = 1'b1;
          q_rec.byte_val = d_name;
          q_rec.kind     = adec_pkg::KIND_NAME;
        end
      end
      adec_pkg::PH_SIZE: begin
        if (word_last && (word_v == 32'd0)) begin
          have            = 1'b1;
          q_rec.entry_end = 1'b1;
        end
      end
      adec_pkg::PH_DATA: begin
        have            = 1'b1;
        q_rec.byte_val  = d_data;
        q_rec.kind      = adec_pkg::KIND_DATA;
        q_rec.entry_end = count_end;
      end
      default: begin
        have = 1'b0;
      end
    endcase
    q_rec.chk = chk;
    if (stream_end && !step_fail) begin
      q_rec.force_out = 1'b1;
      if (boundary) begin
        q_rec.done = 1'b1;
      end else begin
        q_rec.status = adec_pkg::ST_TRUNC;
      end
    end
  end

  assign q_push = step && (have || chk || (stream_end && !step_fail));

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r       <= adec_pkg::PH_HEADER;
      meta_key_r    <= '0;
      data_key_r    <= '0;
      byte_count_r  <= '0;
      field_value_r <= '0;
      name_cut_r    <= 1'b0;
      failed_r      <= 1'b0;
    end else begin
      phase_r       <= phase_nxt;
      meta_key_r    <= meta_key_nxt;
      data_key_r    <= data_key_nxt;
      byte_count_r  <= byte_count_nxt;
      field_value_r <= field_value_nxt;
      name_cut_r    <= name_cut_nxt;
      failed_r      <= failed_nxt;
    end
  end

  // Configuration registers; unknown indexes are ignored
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      initial_key_r <= adec_pkg::INITIAL_KEY_RST;
      name_limit_r  <= adec_pkg::NAME_LIMIT_RST;
    end else if (cfg_wr) begin
      if (cfg_index == adec_pkg::REG_INITIAL_KEY) begin
        initial_key_r <= cfg_data;
      end
      if (cfg_index == adec_pkg::REG_NAME_LIMIT) begin
        name_limit_r <= cfg_data[15:0];
      end
    end
  end

endmodule

`default_nettype wire

### design/adec_back.sv
// Decoder back end: pops queued candidates, cleans name characters and holds
// the result in an output register. Depends on adec_pkg.
`default_nettype none

module adec_back (
  input  wire logic                clk,
  input  wire logic                rst_n,
  // queue side
  input  wire adec_pkg::adec_rec_t head_rec,
  input  wire logic                q_empty,
  output logic                     q_pop,
  // result output
  output logic                     out_valid,
  input  wire logic                out_ready,
  output logic [7:0]               out_byte,
  output logic [1:0]               kind,
  output logic                     entry_end,
  output logic                     archive_done,
  output logic [2:0]               status
);

  logic       out_valid_r, out_valid_nxt;
  logic [7:0] out_byte_r;
  logic [1:0] kind_r;
  logic       entry_end_r, archive_done_r;
  logic [2:0] status_r;

  logic       bad_char, discard, load;
  logic [7:0] clean_byte;
  logic [1:0] clean_kind;

  // Characters not allowed in a name
  assign bad_char = (head_rec.byte_val < 8'd32) || (head_rec.byte_val == 8'h3C) ||
                    (head_rec.byte_val == 8'h3E) || (head_rec.byte_val == 8'h3A) ||
                    (head_rec.byte_val == 8'h22) || (head_rec.byte_val == 8'h7C) ||
                    (head_rec.byte_val == 8'h3F) || (head_rec.byte_val == 8'h2A);

  // Name cleanup: backslash to slash, dropped byte becomes a bare marker
  always_comb begin
    clean_byte = head_rec.byte_val;
    clean_kind = head_rec.kind;
    if (head_rec.chk) begin
      if (bad_char) begin
        clean_byte = 8'd0;
        clean_kind = adec_pkg::KIND_MARK;
      end else if (head_rec.byte_val == 8'h5C) begin
        clean_byte = 8'h2F;
      end
    end
  end

  assign discard = head_rec.chk && bad_char && !head_rec.force_out;
  assign load    = !out_valid_r || out_ready;
  assign q_pop   = !q_empty && (discard || load);

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (load) begin
      out_valid_nxt = q_pop && !discard;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  // Output payload register
  always_ff @(posedge clk) begin
    if (load && q_pop && !discard) begin
      out_byte_r     <= clean_byte;
      kind_r         <= clean_kind;
      entry_end_r    <= head_rec.entry_end;
      archive_done_r <= head_rec.done;
      status_r       <= head_rec.status;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_byte     = out_byte_r;
  assign kind         = kind_r;
  assign entry_end    = entry_end_r;
  assign archive_done = archive_done_r;
  assign status       = status_r;

endmodule

`default_nettype wire

### design/archive_v1_stream_decryptor_core.sv
// Top level of the version-1 archive stream decryptor.
// Depends on adec_pkg, the channel interfaces, adec_front, adec_fifo and adec_back.
`default_nettype none

// Decrypts a version-1 archive fed one byte per transfer on in_ch and gives
// name bytes, data bytes and markers on out_ch, zero or one result per input
// byte. The block takes one byte every cycle: the front keeps all keys and
// counters and updates them for each byte taken, with at most one key step,
// and a four-entry queue plus the output register let input keep flowing
// while a result waits; input stalls only once the queue is full. A result
// passes through the queue and then the output register. Any error status
// is sticky: after it no more results come until reset. Configuration
// writes on cfg_ch are always taken and must happen while the block is idle.
module archive_v1_stream_decryptor_core (
  input  wire logic   clk,
  input  wire logic   rst_n,
  adec_in_if.sink     in_ch,
  adec_out_if.source  out_ch,
  adec_cfg_if.sink    cfg_ch
);

  adec_pkg::adec_rec_t push_rec, head_rec;
  logic                q_push, q_pop, q_full, q_empty;

  assign cfg_ch.ready = 1'b1;

  // Front: byte intake, layout tracking, key stepping
  adec_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_ch.valid),
    .in_ready   (in_ch.ready),
    .in_byte    (in_ch.in_byte),
    .stream_end (in_ch.stream_end),
    .cfg_wr     (cfg_ch.valid),
    .cfg_index  (cfg_ch.index),
    .cfg_data   (cfg_ch.data),
    .q_full     (q_full),
    .q_push     (q_push),
    .q_rec      (push_rec)
  );

  // Queue between the halves
  adec_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_rec (push_rec),
    .full     (q_full),
    .pop      (q_pop),
    .head_rec (head_rec),
    .empty    (q_empty)
  );

  // Back: name cleanup and output register
  adec_back u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .head_rec     (head_rec),
    .q_empty      (q_empty),
    .q_pop        (q_pop),
    .out_valid    (out_ch.valid),
    .out_ready    (out_ch.ready),
    .out_byte     (out_ch.out_byte),
    .kind         (out_ch.kind),
    .entry_end    (out_ch.entry_end),
    .archive_done (out_ch.archive_done),
    .status       (out_ch.status)
  );

endmodule

`default_nettype wire

### tb/archive_v1_stream_decryptor_core_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for archive_v1_stream_decryptor_core: encrypts random archives,
// predicts every decrypted name byte, data byte and marker, and compares them in order.
// Depends on adec_pkg, adec_in_if, adec_out_if, adec_cfg_if and the design top level.

module archive_v1_stream_decryptor_core_tb;
  import adec_pkg::*;

  // First seven bytes of the archive signature, byte 0 in the top lane
  localparam logic [55:0] SIG_HEAD = 56'h52_47_53_53_41_44_00;
  // Name characters the block removes, plus backslash which it rewrites
  localparam logic [63:0] BARRED_CHARS = "\\<>:\"|?*";
  // Index with no register behind it
  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;
  localparam int STALL_LIMIT = 5000;
  localparam int ITEM_GOAL = 550;

  typedef struct packed {
    logic [7:0] val;
    logic [1:0] kind;
    logic       last_of_entry;
    logic       done;
    logic [2:0] status;
  } dec_result_t;

  typedef struct {
    logic [7:0] b;
    logic       e;
  } raw_item_t;

  // Tracks the decoder state, keeps the decrypted results still due, and checks them
  class decrypt_tracker;
    logic [31:0] start_key = INITIAL_KEY_RST;
    logic [15:0] len_cap = NAME_LIMIT_RST;
    phase_t      ph = PH_HEADER;
    logic [31:0] mkey = '0;
    logic [31:0] dkey = '0;
    logic [31:0] cnt = '0;
    logic [31:0] fld = '0;
    bit          cut = 0;
    bit          halted = 0;
    dec_result_t due[$];
    int          errors = 0;

    static function logic [31:0] lcg_next(logic [31:0] k);
      return k * 32'd7 + 32'd3;
    endfunction

    static function logic [7:0] sig_byte(int i);
      return SIG_HEAD[55 - 8 * i -: 8];
    endfunction

    function int pending();
      return due.size();
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] data);
      if (idx == REG_INITIAL_KEY) start_key = data;
      else if (idx == REG_NAME_LIMIT) len_cap = data[15:0];
    endfunction

    function void restart_stream();
      ph = PH_HEADER;
      mkey = '0;
      dkey = '0;
      cnt = '0;
      fld = '0;
      cut = 0;
    endfunction

    // One accepted archive byte: advance the state, queue the result it causes
    function void take_byte(logic [7:0] b, logic e);
      dec_result_t r;
      bit          have;
      logic [31:0] v;
      logic [7:0]  d;
      logic [1:0]  lane;
      r = '{val: 8'h00, kind: KIND_MARK, last_of_entry: 1'b0, done: 1'b0, status: ST_OK};
      have = 0;
      if (halted) return;
      case (ph)
        PH_HEADER: begin
          if (cnt < 7) begin
            if (b != sig_byte(cnt)) fld[0] = 1'b1;
            cnt++;
          end else begin
            if (fld != 0 || (b != VER_ONE && b != VER_THREE)) r.status = ST_BAD_MAGIC;
            else if (b == VER_THREE) r.status = ST_UNSUP;
            if (r.status != ST_OK) begin
              halted = 1;
              have = 1;
            end else begin
              mkey = start_key;
              ph = PH_NAMELEN;
              cnt = 0;
              fld = 0;
            end
          end
        end
        PH_NAMELEN: begin
          fld[8 * cnt[1:0] +: 8] = b;
          cnt++;
          if (cnt >= 4) begin
            v = fld ^ mkey;
            mkey = lcg_next(mkey);
            if (v == 0 || v > {16'd0, len_cap}) begin
              r.status = ST_BAD_NAME;
              halted = 1;
              have = 1;
            end else begin
              fld = v;
              cnt = 0;
              cut = 0;
              ph = PH_NAME;
            end
          end
        end
        PH_NAME: begin
          d = b ^ mkey[7:0];
          mkey = lcg_next(mkey);
          cnt++;
          if (!cut) begin
            // a decrypted zero ends the visible name
            if (d == 8'h00) cut = 1;
            else if (!(d < 8'd32 || d == "<" || d == ">" || d == ":" || d == "\"" ||
                       d == "|" || d == "?" || d == "*")) begin
              r.val = (d == "\\") ? "/" : d;
              r.kind = KIND_NAME;
              have = 1;
            end
          end
          if (cnt >= fld) begin
            ph = PH_SIZE;
            cnt = 0;
            fld = 0;
            cut = 0;
          end
        end
        PH_SIZE: begin
          fld[8 * cnt[1:0] +: 8] = b;
          cnt++;
          if (cnt >= 4) begin
            v = fld ^ mkey;
            mkey = lcg_next(mkey);
            dkey = mkey;
            cnt = 0;
            if (v == 0) begin
              // empty entry: marker only
              fld = 0;
              ph = PH_NAMELEN;
              r.last_of_entry = 1'b1;
              have = 1;
            end else begin
              fld = v;
              ph = PH_DATA;
            end
          end
        end
        PH_DATA: begin
          lane = cnt[1:0];
          r.val = b ^ dkey[8 * lane +: 8];
          r.kind = KIND_DATA;
          have = 1;
          if (lane == 2'd3) dkey = lcg_next(dkey);
          cnt++;
          if (cnt >= fld) begin
            r.last_of_entry = 1'b1;
            ph = PH_NAMELEN;
            cnt = 0;
            fld = 0;
          end
        end
        default: restart_stream();
      endcase
      // end of stream: clean only at an entry boundary
      if (e && !halted) begin
        if (ph == PH_NAMELEN && cnt == 0) begin
          r.done = 1'b1;
          restart_stream();
        end else begin
          r.status = ST_TRUNC;
          halted = 1;
        end
        have = 1;
      end
      if (have) due.push_back(r);
    endfunction

    function void check_field(string what, int unsigned want, int unsigned got);
      if (want != got) begin
        errors++;
        $display("%0t: %s mismatch: expected %0h, actual %0h", $time, what, want, got);
      end
    endfunction

    // One accepted result against the oldest one due
    function void match_result(dec_result_t got);
      dec_result_t want;
      if (due.size() == 0) begin
        errors++;
        $display("%0t: unexpected result: expected none, actual %0h/%0d/%0b/%0b/%0d",
                 $time, got.val, got.kind, got.last_of_entry, got.done, got.status);
        return;
      end
      want = due.pop_front();
      check_field("out_byte", want.val, got.val);
      check_field("kind", want.kind, got.kind);
      check_field("entry_end", want.last_of_entry, got.last_of_entry);
      check_field("archive_done", want.done, got.done);
      check_field("status", want.status, got.status);
    endfunction
  endclass

  logic clk;
  logic rst_n;

  adec_in_if  in_ch();
  adec_out_if out_ch();
  adec_cfg_if cfg_ch();

  archive_v1_stream_decryptor_core uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  decrypt_tracker tracker = new();

  raw_item_t   plan[$];
  logic [31:0] cur_key = INITIAL_KEY_RST;
  logic [15:0] cur_limit = NAME_LIMIT_RST;
  logic [31:0] gen_key;
  bit          quiet = 0;
  int          bytes_sent = 0;
  int          stall_cycles;
  dec_result_t seen_res;

  // Clock
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Result side backpressure
  always @(negedge clk) begin
    out_ch.ready <= quiet || ($urandom_range(0, 99) >= 17);
  end

  // Transfer monitor: check results, then note accepted bytes
  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      seen_res.val = out_ch.out_byte;
      seen_res.kind = out_ch.kind;
      seen_res.last_of_entry = out_ch.entry_end;
      seen_res.done = out_ch.archive_done;
      seen_res.status = out_ch.status;
      tracker.match_result(seen_res);
    end
    if (rst_n && in_ch.valid && in_ch.ready)
      tracker.take_byte(in_ch.in_byte, in_ch.stream_end);
  end

  // Watchdog: too long without any transfer ends the run
  initial begin
    stall_cycles = 0;
    while (stall_cycles < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
          (cfg_ch.valid && cfg_ch.ready)) stall_cycles = 0;
      else stall_cycles++;
    end
    $display("Regression FAIL");
    $finish;
  end

  // Send one byte, with random idle cycles ahead of it
  task automatic push_byte(input logic [7:0] b, input logic e);
    while (!quiet && $urandom_range(0, 99) < 17) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.in_byte <= b;
    in_ch.stream_end <= e;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    bytes_sent++;
    @(negedge clk);
  endtask

  // Stop sending until every due result has come, plus the pipeline latency
  task automatic wait_drain();
    in_ch.valid <= 1'b0;
    while (tracker.pending() != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  // Send the planned bytes; optionally drain before one of them
  task automatic send_plan(input int pause_at);
    for (int i = 0; i < plan.size(); i++) begin
      if (i == pause_at) wait_drain();
      push_byte(plan[i].b, plan[i].e);
    end
    plan.delete();
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] data);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data <= data;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    tracker.set_reg(idx, data);
    if (idx == REG_INITIAL_KEY) cur_key = data;
    else if (idx == REG_NAME_LIMIT) cur_limit = data[15:0];
    @(negedge clk);
  endtask

  // New register setting between archives; upper limit bits are don't-care
  task automatic reconfigure(input logic [31:0] k, input logic [15:0] lim);
    wait_drain();
    if ($urandom_range(0, 1) == 0) begin
      write_reg(REG_INITIAL_KEY, k);
      write_reg(REG_NAME_LIMIT, ($urandom & 32'hFFFF_0000) | {16'd0, lim});
    end else begin
      write_reg(REG_NAME_LIMIT, ($urandom & 32'hFFFF_0000) | {16'd0, lim});
      write_reg(REG_INITIAL_KEY, k);
    end
    if ($urandom_range(0, 4) == 0) write_reg(REG_SPARE, $urandom);
    cfg_ch.valid <= 1'b0;
  endtask

  // Signature and version byte; bad_pos >= 0 corrupts one signature byte
  task automatic plan_header(input logic [7:0] ver, input int bad_pos, input logic [7:0] flip);
    for (int i = 0; i < 7; i++)
      plan.push_back('{decrypt_tracker::sig_byte(i) ^ ((i == bad_pos) ? flip : 8'h00), 1'b0});
    plan.push_back('{ver, 1'b0});
    gen_key = cur_key;
  endtask

  // 32-bit little-endian field under the metadata key
  task automatic plan_word(input logic [31:0] v);
    logic [31:0] w;
    w = v ^ gen_key;
    gen_key = decrypt_tracker::lcg_next(gen_key);
    for (int i = 0; i < 4; i++) plan.push_back('{w[8 * i +: 8], 1'b0});
  endtask

  task automatic plan_name_char(input logic [7:0] p);
    plan.push_back('{p ^ gen_key[7:0], 1'b0});
    gen_key = decrypt_tracker::lcg_next(gen_key);
  endtask

  // Name text mixing printable, barred, control, zero and high characters
  task automatic plan_name(input int n);
    logic [7:0] p;
    int         r;
    int         pick;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(0, 99);
      pick = $urandom_range(0, 7);
      if (r < 55) p = 8'($urandom_range(32, 126));
      else if (r < 68) p = BARRED_CHARS[8 * pick +: 8];
      else if (r < 80) p = 8'($urandom_range(1, 31));
      else if (r < 83) p = 8'h00;
      else p = 8'($urandom_range(127, 255));
      plan_name_char(p);
    end
  endtask

  task automatic plan_entry(input int nlen, input int dlen);
    plan_word(nlen);
    plan_name(nlen);
    plan_word(dlen);
    for (int i = 0; i < dlen; i++) plan.push_back('{8'($urandom_range(0, 255)), 1'b0});
  endtask

  // Mostly short names, now and then the longest the limit allows (capped)
  function automatic int pick_name_len();
    int hi;
    hi = (cur_limit < 12) ? cur_limit : 12;
    if ($urandom_range(0, 19) == 0) hi = (cur_limit < 160) ? cur_limit : 160;
    if ($urandom_range(0, 7) == 0) return hi;
    return $urandom_range(1, hi);
  endfunction

  // Data sizes hit empty entries and every tail length
  function automatic int pick_data_len();
    int r;
    r = $urandom_range(0, 9);
    if (r < 2) return 0;
    if (r == 9) return $urandom_range(10, 40);
    return $urandom_range(1, 9);
  endfunction

  // Final archive that fails; the block must go silent afterwards
  task automatic plan_broken_tail();
    logic [7:0]  ver;
    logic [31:0] v;
    int          cut_at;
    case ($urandom_range(0, 4))
      0: plan_header(VER_ONE, $urandom_range(0, 6), 8'($urandom_range(1, 255)));
      1: begin
        ver = 8'($urandom_range(0, 255));
        if (ver == VER_ONE || ver == VER_THREE) ver = ver ^ 8'h80;
        plan_header(ver, -1, 8'h00);
      end
      2: plan_header(VER_THREE, -1, 8'h00);
      3: begin
        plan_header(VER_ONE, -1, 8'h00);
        if ($urandom_range(0, 1) == 0) plan_entry(pick_name_len(), pick_data_len());
        case ($urandom_range(0, 2))
          0: v = 32'd0;
          1: v = {16'd0, cur_limit} + 32'd1;
          default: v = $urandom_range({16'd0, cur_limit} + 32'd1, 32'hFFFF_FFFF);
        endcase
        plan_word(v);
      end
      default: begin
        // stream end anywhere but an entry boundary
        plan_header(VER_ONE, -1, 8'h00);
        plan_entry(pick_name_len(), $urandom_range(1, 9));
        cut_at = $urandom_range(0, plan.size() - 2);
        if (cut_at == 7) cut_at = 6;
        plan[cut_at].e = 1'b1;
        while (plan.size() > cut_at + 1) void'(plan.pop_back());
      end
    endcase
    repeat (12) plan.push_back('{8'($urandom_range(0, 255)), 1'($urandom_range(0, 1))});
  endtask

  // Stimulus
  initial begin
    int          arch;
    int          entries;
    int          pause_at;
    logic [31:0] k;
    logic [15:0] lim;

    in_ch.valid = 1'b0;
    in_ch.in_byte = 8'h00;
    in_ch.stream_end = 1'b0;
    out_ch.ready = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = REG_INITIAL_KEY;
    cfg_ch.data = 32'd0;
    rst_n = 1'b0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed: clean end right after the header
    plan_header(VER_ONE, -1, 8'h00);
    plan[7].e = 1'b1;
    send_plan(-1);
    // Directed: backslash, barred char, zero cut, empty data ending the archive
    plan_header(VER_ONE, -1, 8'h00);
    plan_word(32'd4);
    plan_name_char("\\");
    plan_name_char("*");
    plan_name_char(8'h00);
    plan_name_char("b");
    plan_word(32'd0);
    plan[plan.size() - 1].e = 1'b1;
    send_plan(-1);

    // Random well-formed archives under changing settings
    arch = 0;
    while (bytes_sent < ITEM_GOAL) begin
      if (arch == 0) reconfigure(32'd0, 16'd1);
      else if (arch == 5) reconfigure(32'hFFFF_FFFF, 16'hFFFF);
      else if ($urandom_range(0, 2) == 0) begin
        case ($urandom_range(0, 3))
          0: k = 32'd0;
          1: k = 32'hFFFF_FFFF;
          2: k = INITIAL_KEY_RST;
          default: k = $urandom;
        endcase
        case ($urandom_range(0, 3))
          0: lim = 16'd1;
          1: lim = 16'hFFFF;
          2: lim = 16'($urandom_range(1, 24));
          default: lim = NAME_LIMIT_RST;
        endcase
        reconfigure(k, lim);
      end
      quiet = (bytes_sent >= 200 && bytes_sent < 330);
      entries = $urandom_range(0, 3);
      plan_header(VER_ONE, -1, 8'h00);
      for (int i = 0; i < entries; i++) plan_entry(pick_name_len(), pick_data_len());
      plan[plan.size() - 1].e = 1'b1;
      pause_at = -1;
      if (arch == 2) pause_at = plan.size() / 2;
      else if ($urandom_range(0, 5) == 0) pause_at = $urandom_range(1, plan.size() - 1);
      send_plan(pause_at);
      arch++;
    end
    quiet = 0;

    plan_broken_tail();
    send_plan(-1);

    // Drain and finish
    in_ch.valid <= 1'b0;
    while (tracker.pending() != 0) @(negedge clk);
    repeat (20) @(negedge clk);
    if (tracker.errors == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end

endmodule

### files.f
design/adec_pkg.sv
design/adec_in_if.sv
design/adec_out_if.sv
design/adec_cfg_if.sv
design/adec_fifo.sv
design/adec_front.sv
design/adec_back.sv
design/archive_v1_stream_decryptor_core.sv
tb/archive_v1_stream_decryptor_core_tb.sv
